>>> rtl/npc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette color search package
// Shared constants and word types of the palette search block.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int ENTRIES = 256;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int COLOR_W = 8;
   localparam int SIZE_W  = 9;
   localparam int SCORE_W = 19;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic REG_PALETTE_SIZE = 1'b0;

   typedef struct packed {
      logic               command;
      logic [7:0]         entry_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [7:0]         map_slot;
   } req_word_type;

   typedef struct packed {
      logic [7:0] slot_out;
      logic [7:0] color_index;
   } rsp_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

endpackage

>>> rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette color search
// A palette write is accepted only while idle and is stored in the palette. A
// query reads one entry per cycle and stops early on an exact match; with
// palette_size below 2 no entry is read. The next word is taken in the same
// cycle in which the result has moved to the output register.
// Reset sets palette_size to 256; the palette stays undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  npc_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output npc_pkg::rsp_word_type          rsp_word,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [npc_pkg::PADDR_W-1:0]    paddr,
   input  logic [npc_pkg::PDATA_W-1:0]    pwdata,
   output logic [npc_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   npc_pkg::color_type pal_mem [npc_pkg::ENTRIES];

   logic [1:0]                       state_ff, state_in;
   logic [npc_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [npc_pkg::CNT_W-1:0]        lim_ff, lim_in;
   logic [npc_pkg::CNT_W-1:0]        addr_ff, addr_in;
   npc_pkg::color_type               query_ff, query_in;
   logic [7:0]                       slot_ff, slot_in;
   npc_pkg::color_type               rd_data_ff;
   logic                             rd_vld_ff, rd_vld_in;
   logic [npc_pkg::ADDR_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                             sc_vld_ff, sc_vld_in;
   logic [npc_pkg::ADDR_W-1:0]       sc_idx_ff, sc_idx_in;
   logic [npc_pkg::SCORE_W-1:0]      score_ff, score_in;
   logic [npc_pkg::ADDR_W-1:0]       best_idx_ff, best_idx_in;
   logic [npc_pkg::SCORE_W-1:0]      best_score_ff, best_score_in;
   logic                             have_best_ff, have_best_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   npc_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                             req_acc;
   logic                             cfg_wr;
   logic                             pal_wr;
   logic [npc_pkg::CNT_W-1:0]        lim_new;
   logic                             found_now;
   logic                             issue;
   logic                             scan_done;
   logic                             out_free;

   function automatic logic [npc_pkg::SCORE_W-1:0] color_score(
      input npc_pkg::color_type a,
      input npc_pkg::color_type b
   );
      logic [7:0]  dr, dg, db;
      logic [15:0] sr, sg, sb;
      dr = (a.red > b.red) ? (a.red - b.red) : (b.red - a.red);
      dg = (a.green > b.green) ? (a.green - b.green) : (b.green - a.green);
      db = (a.blue > b.blue) ? (a.blue - b.blue) : (b.blue - a.blue);
      sr = 16'(dr) * 16'(dr);
      sg = 16'(dg) * 16'(dg);
      sb = 16'(db) * 16'(db);
      return (npc_pkg::SCORE_W'(sr) << 1) + (npc_pkg::SCORE_W'(sg) << 1)
           + npc_pkg::SCORE_W'(sg) + npc_pkg::SCORE_W'(sb);
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite && pready
                      && (paddr[2] == npc_pkg::REG_PALETTE_SIZE);
   assign prdata    = (paddr[2] == npc_pkg::REG_PALETTE_SIZE)
                      ? npc_pkg::PDATA_W'(size_ff) : '0;
   assign pal_wr    = req_acc && (req_word.command == npc_pkg::CMD_WRITE)
                      && (32'(req_word.entry_index) < npc_pkg::ENTRIES);
   assign lim_new   = (32'(size_ff) > npc_pkg::ENTRIES)
                      ? npc_pkg::CNT_W'(npc_pkg::ENTRIES)
                      : npc_pkg::CNT_W'(size_ff);
   assign found_now = sc_vld_ff && (score_ff == '0);
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < lim_ff) && !found_now;
   assign scan_done = found_now || ((addr_ff == lim_ff) && !rd_vld_ff && !sc_vld_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      size_in       = cfg_wr ? pwdata[npc_pkg::SIZE_W-1:0] : size_ff;
      lim_in        = lim_ff;
      addr_in       = issue ? addr_ff + npc_pkg::CNT_W'(1) : addr_ff;
      query_in      = query_ff;
      slot_in       = slot_ff;
      rd_vld_in     = issue;
      rd_idx_in     = addr_ff[npc_pkg::ADDR_W-1:0];
      sc_vld_in     = rd_vld_ff && !found_now;
      sc_idx_in     = rd_idx_ff;
      score_in      = color_score(rd_data_ff, query_ff);
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      have_best_in  = have_best_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;

      if (found_now) begin
         best_idx_in = sc_idx_ff;
      end else if (sc_vld_ff && (!have_best_ff || score_ff < best_score_ff)) begin
         best_idx_in   = sc_idx_ff;
         best_score_in = score_ff;
         have_best_in  = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_word.command == npc_pkg::CMD_QUERY) begin
               query_in.red   = req_word.red;
               query_in.green = req_word.green;
               query_in.blue  = req_word.blue;
               slot_in        = req_word.map_slot;
               lim_in         = lim_new;
               addr_in        = npc_pkg::CNT_W'(1);
               best_idx_in    = '0;
               have_best_in   = 1'b0;
               state_in       = (lim_new < npc_pkg::CNT_W'(2)) ? ST_HOLD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.slot_out    = slot_ff;
               rsp_word_in.color_index = 8'(best_idx_ff);
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[npc_pkg::ADDR_W'(req_word.entry_index)] <=
            {req_word.red, req_word.green, req_word.blue};
      end
      rd_data_ff <= pal_mem[addr_ff[npc_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= npc_pkg::SIZE_RESET;
         rd_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rd_vld_ff    <= rd_vld_in;
         sc_vld_ff    <= sc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff        <= lim_in;
      addr_ff       <= addr_in;
      query_ff      <= query_in;
      slot_ff       <= slot_in;
      rd_idx_ff     <= rd_idx_in;
      sc_idx_ff     <= sc_idx_in;
      score_ff      <= score_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      have_best_ff  <= have_best_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_vld_ff && !sc_vld_ff))
      else $error("Scan pipeline busy while idle.");

   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (npc_pkg::CNT_W'(rd_idx_ff) < lim_ff))
      else $error("Palette read beyond the entries in use.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && found_now) |=> (!rd_vld_ff && !sc_vld_ff))
      else $error("Scan pipeline not flushed after an exact match.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("Result word appeared outside the hold state.");

endmodule
